// File: hdl/tacf_pkg.sv
// Shared types, constants and CORDIC angle table for the tilt angle filter.
package tacf_pkg;

    // Number of pipelined CORDIC iterations (at most 24 table entries exist).
    localparam int CORDIC_STAGES = 16;
    localparam int CORDIC_N      = (CORDIC_STAGES > 24) ? 24 : CORDIC_STAGES;

    // Square root of a 40-bit value takes 20 digit steps, two per stage.
    localparam int SQRT_ST  = 10;

    // Lane stages: squares, square root, CORDIC, output scaling.
    localparam int LANE_LAT = 1 + SQRT_ST + CORDIC_N + 1;

    localparam int ACC_LIM   = 11520;
    localparam int FUSED_LIM = 23040;

    localparam logic [7:0] REG_GYRO_WEIGHT     = 8'd0;
    localparam logic [7:0] REG_STILL_THRESHOLD = 8'd1;

    localparam logic [15:0] GYRO_WEIGHT_RST     = 16'd64225;
    localparam logic [17:0] STILL_THRESHOLD_RST = 18'd13;

    // atan(2^-i) in degrees, Q16.
    localparam logic signed [25:0] ATAN_Q16 [24] = '{
        26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
        26'sd234379,  26'sd117304,  26'sd58666,  26'sd29335,
        26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
        26'sd917,     26'sd458,     26'sd229,    26'sd115,
        26'sd57,      26'sd29,      26'sd14,     26'sd7,
        26'sd4,       26'sd2,       26'sd1,      26'sd0
    };

    typedef struct packed {
        logic [23:0] rem;
        logic [19:0] root;
        logic [39:0] v;
    } t_sq;

    // One digit step of the integer square root.
    function automatic t_sq sq_iter(input t_sq s);
        t_sq         r;
        logic [23:0] rem2;
        logic [23:0] trial;
        rem2  = {s.rem[21:0], s.v[39:38]};
        trial = {2'b00, s.root, 2'b01};
        r.v   = {s.v[37:0], 2'b00};
        if (rem2 >= trial) begin
            r.rem  = rem2 - trial;
            r.root = {s.root[18:0], 1'b1};
        end else begin
            r.rem  = rem2;
            r.root = {s.root[18:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// File: hdl/tacf_tilt.sv
// One tilt lane: atan2(num, sqrt(a^2+b^2)) in Q7 degrees, pipelined square root and CORDIC.
module tacf_tilt (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic signed [15:0] i_num,
    input  logic signed [15:0] i_a,
    input  logic signed [15:0] i_b,
    output logic signed [14:0] o_angle
);

    logic [31:0]        r_aa;
    logic [31:0]        r_bb;
    logic signed [15:0] r_num0;

    tacf_pkg::t_sq      w_sq  [tacf_pkg::SQRT_ST+1];
    tacf_pkg::t_sq      r_sq  [tacf_pkg::SQRT_ST];
    logic signed [15:0] r_num [tacf_pkg::SQRT_ST];

    logic signed [23:0] w_x [tacf_pkg::CORDIC_N+1];
    logic signed [23:0] w_y [tacf_pkg::CORDIC_N+1];
    logic signed [25:0] w_z [tacf_pkg::CORDIC_N+1];
    logic               w_zf [tacf_pkg::CORDIC_N+1];
    logic signed [23:0] r_x [tacf_pkg::CORDIC_N];
    logic signed [23:0] r_y [tacf_pkg::CORDIC_N];
    logic signed [25:0] r_z [tacf_pkg::CORDIC_N];
    logic               r_zf [tacf_pkg::CORDIC_N];

    logic signed [25:0] w_zr;
    logic signed [16:0] w_q7;
    logic signed [14:0] n_angle;
    logic signed [14:0] r_angle;

    logic signed [31:0] w_pa;
    logic signed [31:0] w_pb;
    logic [31:0]        w_sum;

    assign w_pa = i_a * i_a;
    assign w_pb = i_b * i_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_aa   <= w_pa;
            r_bb   <= w_pb;
            r_num0 <= i_num;
        end
    end

    assign w_sum = r_aa + r_bb;
    always_comb begin
        w_sq[0].rem  = '0;
        w_sq[0].root = '0;
        w_sq[0].v    = {w_sum, 8'b0};
    end

    for (genvar g = 0; g < tacf_pkg::SQRT_ST; g++) begin : g_sqrt
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_sq[g]  <= tacf_pkg::sq_iter(tacf_pkg::sq_iter(w_sq[g]));
                r_num[g] <= (g == 0) ? r_num0 : r_num[(g == 0) ? 0 : g-1];
            end
        end
        assign w_sq[g+1] = r_sq[g];
    end

    assign w_x[0]  = {4'b0000, w_sq[tacf_pkg::SQRT_ST].root};
    assign w_y[0]  = {{4{r_num[tacf_pkg::SQRT_ST-1][15]}},
                      r_num[tacf_pkg::SQRT_ST-1], 4'b0000};
    assign w_z[0]  = '0;
    assign w_zf[0] = (r_num[tacf_pkg::SQRT_ST-1] == 16'sd0);

    for (genvar gi = 0; gi < tacf_pkg::CORDIC_N; gi++) begin : g_cordic
        logic signed [23:0] xs;
        logic signed [23:0] ys;
        assign xs = w_x[gi] >>> gi;
        assign ys = w_y[gi] >>> gi;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                if (!w_y[gi][23]) begin
                    r_x[gi] <= w_x[gi] + ys;
                    r_y[gi] <= w_y[gi] - xs;
                    r_z[gi] <= w_z[gi] + tacf_pkg::ATAN_Q16[gi];
                end else begin
                    r_x[gi] <= w_x[gi] - ys;
                    r_y[gi] <= w_y[gi] + xs;
                    r_z[gi] <= w_z[gi] - tacf_pkg::ATAN_Q16[gi];
                end
                r_zf[gi] <= w_zf[gi];
            end
        end
        assign w_x[gi+1]  = r_x[gi];
        assign w_y[gi+1]  = r_y[gi];
        assign w_z[gi+1]  = r_z[gi];
        assign w_zf[gi+1] = r_zf[gi];
    end

    // Round Q16 to Q7 and saturate; a zero numerator gives exactly zero.
    assign w_zr = (w_z[tacf_pkg::CORDIC_N] + 26'sd256) >>> 9;
    assign w_q7 = w_zr[16:0];
    always_comb begin
        if (w_zf[tacf_pkg::CORDIC_N]) begin
            n_angle = '0;
        end else if (w_q7 > 17'(tacf_pkg::ACC_LIM)) begin
            n_angle = 15'(tacf_pkg::ACC_LIM);
        end else if (w_q7 < -17'(tacf_pkg::ACC_LIM)) begin
            n_angle = -15'(tacf_pkg::ACC_LIM);
        end else begin
            n_angle = w_q7[14:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_angle <= n_angle;
        end
    end

    assign o_angle = r_angle;

endmodule

// File: hdl/tilt_angle_complementary_filter_unit.sv
// Top level: accelerometer tilt angles blended with gyro angles by a complementary filter.
// Throughput: one item per cycle while not stalled; 28 lane stages (squares, 10 square
// root stages, 16 CORDIC stages, scaling), two blend stages. The whole pipeline holds
// while a result waits under stall. Reset clears the valid bits and loads the register
// defaults; data registers are not reset.
module tilt_angle_complementary_filter_unit (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [15:0] i_accel_x,
    input  logic signed [15:0] i_accel_y,
    input  logic signed [15:0] i_accel_z,
    input  logic signed [15:0] i_gyro_roll_angle,
    input  logic signed [15:0] i_gyro_pitch_angle,
    input  logic signed [18:0] i_roll_rate,
    input  logic signed [18:0] i_pitch_rate,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [14:0] o_accel_roll,
    output logic signed [14:0] o_accel_pitch,
    output logic signed [15:0] o_fused_roll,
    output logic signed [15:0] o_fused_pitch,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [7:0]         i_cfg_index,
    input  logic [17:0]        i_cfg_data
);

    localparam int L = tacf_pkg::LANE_LAT;

    logic               w_en;
    logic [15:0]        r_weight;
    logic [17:0]        r_thresh;

    logic               r_vld [L];
    logic signed [15:0] r_gr  [L];
    logic signed [15:0] r_gp  [L];
    logic signed [18:0] r_rr  [L];
    logic signed [18:0] r_rp  [L];

    logic signed [14:0] w_roll;
    logic signed [14:0] w_lane_p;
    logic signed [14:0] w_pitch;

    logic               r_b_vld;
    logic signed [32:0] r_g_r;
    logic signed [32:0] r_a_r;
    logic signed [32:0] r_g_p;
    logic signed [32:0] r_a_p;
    logic               r_still_r;
    logic               r_still_p;
    logic signed [14:0] r_acc_r;
    logic signed [14:0] r_acc_p;

    logic signed [17:0] w_wgt;
    logic signed [17:0] w_cwgt;
    logic [18:0]        w_mag_r;
    logic [18:0]        w_mag_p;
    logic signed [15:0] n_fr;
    logic signed [15:0] n_fp;

    logic               r_out_vld;
    logic signed [14:0] r_out_ar;
    logic signed [14:0] r_out_ap;
    logic signed [15:0] r_out_fr;
    logic signed [15:0] r_out_fp;

    assign w_en        = !(r_out_vld && i_stall);
    assign o_stall     = !w_en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= tacf_pkg::GYRO_WEIGHT_RST;
            r_thresh <= tacf_pkg::STILL_THRESHOLD_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tacf_pkg::REG_GYRO_WEIGHT:     r_weight <= i_cfg_data[15:0];
                tacf_pkg::REG_STILL_THRESHOLD: r_thresh <= i_cfg_data;
                default: ;
            endcase
        end
    end

    tacf_tilt u_roll (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_accel_y),
        .i_a     (i_accel_x),
        .i_b     (i_accel_z),
        .o_angle (w_roll)
    );

    tacf_tilt u_pitch (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_num   (i_accel_x),
        .i_a     (i_accel_y),
        .i_b     (i_accel_z),
        .o_angle (w_lane_p)
    );

    assign w_pitch = -w_lane_p;

    for (genvar g = 0; g < L; g++) begin : g_dly
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (w_en) begin
                r_vld[g] <= (g == 0) ? i_valid : r_vld[(g == 0) ? 0 : g-1];
            end
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_gr[g] <= (g == 0) ? i_gyro_roll_angle  : r_gr[(g == 0) ? 0 : g-1];
                r_gp[g] <= (g == 0) ? i_gyro_pitch_angle : r_gp[(g == 0) ? 0 : g-1];
                r_rr[g] <= (g == 0) ? i_roll_rate        : r_rr[(g == 0) ? 0 : g-1];
                r_rp[g] <= (g == 0) ? i_pitch_rate       : r_rp[(g == 0) ? 0 : g-1];
            end
        end
    end

    assign w_wgt   = $signed({2'b00, r_weight});
    assign w_cwgt  = $signed(18'd65536 - {2'b00, r_weight});
    assign w_mag_r = r_rr[L-1][18] ? 19'(-r_rr[L-1]) : 19'(r_rr[L-1]);
    assign w_mag_p = r_rp[L-1][18] ? 19'(-r_rp[L-1]) : 19'(r_rp[L-1]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (w_en) begin
            r_b_vld <= r_vld[L-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_g_r     <= 33'(w_wgt * r_gr[L-1]);
            r_a_r     <= 33'(w_cwgt * w_roll);
            r_g_p     <= 33'(w_wgt * r_gp[L-1]);
            r_a_p     <= 33'(w_cwgt * w_pitch);
            r_still_r <= (w_mag_r < {1'b0, r_thresh});
            r_still_p <= (w_mag_p < {1'b0, r_thresh});
            r_acc_r   <= w_roll;
            r_acc_p   <= w_pitch;
        end
    end

    // Weighted sum, rounded to Q7 and saturated, or the accel angle on a still axis.
    always_comb begin
        logic signed [34:0] s_r;
        logic signed [34:0] s_p;
        logic signed [18:0] q_r;
        logic signed [18:0] q_p;
        s_r = 35'(r_g_r) + 35'(r_a_r) + 35'sd32768;
        s_p = 35'(r_g_p) + 35'(r_a_p) + 35'sd32768;
        q_r = 19'(s_r >>> 16);
        q_p = 19'(s_p >>> 16);
        if (r_still_r) begin
            n_fr = 16'(r_acc_r);
        end else if (q_r > 19'(tacf_pkg::FUSED_LIM)) begin
            n_fr = 16'(tacf_pkg::FUSED_LIM);
        end else if (q_r < -19'(tacf_pkg::FUSED_LIM)) begin
            n_fr = -16'(tacf_pkg::FUSED_LIM);
        end else begin
            n_fr = q_r[15:0];
        end
        if (r_still_p) begin
            n_fp = 16'(r_acc_p);
        end else if (q_p > 19'(tacf_pkg::FUSED_LIM)) begin
            n_fp = 16'(tacf_pkg::FUSED_LIM);
        end else if (q_p < -19'(tacf_pkg::FUSED_LIM)) begin
            n_fp = -16'(tacf_pkg::FUSED_LIM);
        end else begin
            n_fp = q_p[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_ar <= r_acc_r;
            r_out_ap <= r_acc_p;
            r_out_fr <= n_fr;
            r_out_fp <= n_fp;
        end
    end

    assign o_valid       = r_out_vld;
    assign o_accel_roll  = r_out_ar;
    assign o_accel_pitch = r_out_ap;
    assign o_fused_roll  = r_out_fr;
    assign o_fused_pitch = r_out_fp;

endmodule

// File: dv/tilt_angle_complementary_filter_unit_tb.sv
// Testbench for the tilt angle complementary filter: driver, monitor and predictor.
module tilt_angle_complementary_filter_unit_tb;

    typedef struct packed {
        logic signed [15:0] ax;
        logic signed [15:0] ay;
        logic signed [15:0] az;
        logic signed [15:0] groll;
        logic signed [15:0] gpitch;
        logic signed [18:0] rroll;
        logic signed [18:0] rpitch;
    } t_sample;

    typedef struct packed {
        logic signed [14:0] roll;
        logic signed [14:0] pitch;
        logic signed [15:0] froll;
        logic signed [15:0] fpitch;
    } t_angles;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_accel_x = '0;
    logic signed [15:0] i_accel_y = '0;
    logic signed [15:0] i_accel_z = '0;
    logic signed [15:0] i_gyro_roll_angle = '0;
    logic signed [15:0] i_gyro_pitch_angle = '0;
    logic signed [18:0] i_roll_rate = '0;
    logic signed [18:0] i_pitch_rate = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [14:0] o_accel_roll;
    logic signed [14:0] o_accel_pitch;
    logic signed [15:0] o_fused_roll;
    logic signed [15:0] o_fused_pitch;
    logic               i_cfg_valid = 1'b0;
    logic               o_cfg_ready;
    logic [7:0]         i_cfg_index = '0;
    logic [17:0]        i_cfg_data = '0;

    tilt_angle_complementary_filter_unit dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_sample pending_samples[$];
    t_angles expected_angles[$];
    longint  weight_q16 = tacf_pkg::GYRO_WEIGHT_RST;
    longint  still_q7 = tacf_pkg::STILL_THRESHOLD_RST;
    int      mismatches = 0;
    int      samples_sent = 0;
    int      angles_seen = 0;
    bit      calm = 1'b0;
    bit      in_taken = 1'b0;
    int      hold_off = 0;

    function automatic longint floor_shr(longint v, int s);
        return (v < 0) ? -1 - ((-1 - v) >>> s) : (v >>> s);
    endfunction

    function automatic longint clamp(longint v, longint lim);
        return (v > lim) ? lim : ((v < -lim) ? -lim : v);
    endfunction

    // Integer square root, digit by digit.
    function automatic longint root_floor(longint v);
        longint r;
        longint b;
        r = 0;
        b = 64'sd1 <<< 60;
        while (b > v) b = b >>> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >>> 1) + b;
            end else begin
                r = r >>> 1;
            end
            b = b >>> 2;
        end
        return r;
    endfunction

    // Vectoring rotation giving atan2(num, sqrt(a^2+b^2)) in Q7 degrees.
    function automatic longint tilt_q7(longint num, longint a, longint b);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        x = root_floor((a * a + b * b) * 256);
        y = num * 16;
        z = 0;
        if (num == 0) return 0;
        for (int i = 0; i < tacf_pkg::CORDIC_N; i++) begin
            xs = floor_shr(x, i);
            ys = floor_shr(y, i);
            if (y >= 0) begin
                x += ys; y -= xs; z += tacf_pkg::ATAN_Q16[i];
            end else begin
                x -= ys; y += xs; z -= tacf_pkg::ATAN_Q16[i];
            end
        end
        return floor_shr(z + 256, 9);
    endfunction

    function automatic longint fuse_axis(longint acc, longint gyro, longint rate);
        longint mag;
        mag = (rate < 0) ? -rate : rate;
        if (mag < still_q7) return acc;
        return clamp(floor_shr(weight_q16 * gyro + (65536 - weight_q16) * acc + 32768, 16),
                     tacf_pkg::FUSED_LIM);
    endfunction

    function automatic t_angles predict_angles(t_sample s);
        t_angles r;
        longint roll;
        longint pitch;
        roll  = clamp(tilt_q7(s.ay, s.ax, s.az), tacf_pkg::ACC_LIM);
        pitch = clamp(-tilt_q7(s.ax, s.ay, s.az), tacf_pkg::ACC_LIM);
        r.roll   = 15'(roll);
        r.pitch  = 15'(pitch);
        r.froll  = 16'(fuse_axis(roll, s.groll, s.rroll));
        r.fpitch = 16'(fuse_axis(pitch, s.gpitch, s.rpitch));
        return r;
    endfunction

    // Records each input item at the edge that accepts it.
    always @(posedge i_clk) begin
        in_taken = i_rst_n && i_valid && !o_stall;
        if (in_taken) begin
            expected_angles.push_back(predict_angles({i_accel_x, i_accel_y, i_accel_z,
                i_gyro_roll_angle, i_gyro_pitch_angle, i_roll_rate, i_pitch_rate}));
        end
    end

    // Receiver hold-off, counted down once per cycle.
    always @(posedge i_clk) begin
        if (hold_off > 0) hold_off <= hold_off - 1;
    end

    // Driver: offers the next sample, holds it while stalled.
    always @(negedge i_clk) begin
        if (!i_valid || in_taken) begin
            if (pending_samples.size() > 0 && (calm || $urandom_range(99) >= 34)) begin
                t_sample s;
                s = pending_samples.pop_front();
                i_valid <= 1'b1;
                i_accel_x <= s.ax;
                i_accel_y <= s.ay;
                i_accel_z <= s.az;
                i_gyro_roll_angle <= s.groll;
                i_gyro_pitch_angle <= s.gpitch;
                i_roll_rate <= s.rroll;
                i_pitch_rate <= s.rpitch;
                samples_sent++;
            end else begin
                i_valid <= 1'b0;
            end
        end
        if (hold_off > 0) begin
            i_stall <= 1'b1;
        end else begin
            i_stall <= calm ? 1'b0 : ($urandom_range(99) < 34);
        end
    end

    // Monitor: compares each result with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            angles_seen++;
            if (expected_angles.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result item: got %0d %0d %0d %0d", o_accel_roll,
                             o_accel_pitch, o_fused_roll, o_fused_pitch);
            end else begin
                t_angles e;
                e = expected_angles.pop_front();
                if (e.roll !== o_accel_roll || e.pitch !== o_accel_pitch ||
                    e.froll !== o_fused_roll || e.fpitch !== o_fused_pitch) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %0d %0d %0d %0d, got %0d %0d %0d %0d",
                                 e.roll, e.pitch, e.froll, e.fpitch, o_accel_roll,
                                 o_accel_pitch, o_fused_roll, o_fused_pitch);
                end
            end
        end
    end

    task automatic write_reg(logic [7:0] idx, logic [17:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == tacf_pkg::REG_GYRO_WEIGHT) weight_q16 = val[15:0];
        else if (idx == tacf_pkg::REG_STILL_THRESHOLD) still_q7 = val;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain;
        while (pending_samples.size() > 0 || i_valid || expected_angles.size() > 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    function automatic t_sample random_sample(bit wide);
        t_sample s;
        s.ax = 16'($urandom); s.ay = 16'($urandom); s.az = 16'($urandom);
        if (!wide && $urandom_range(3) != 0) begin
            // Mostly plausible tilt: small horizontal axes against gravity.
            s.ax = 16'($signed($urandom_range(16000)) - 8000);
            s.ay = 16'($signed($urandom_range(16000)) - 8000);
        end
        if (wide) begin
            s.groll = 16'($urandom); s.gpitch = 16'($urandom);
            s.rroll = 19'($urandom); s.rpitch = 19'($urandom);
        end else begin
            s.groll  = 16'($signed($urandom_range(46080)) - 23040);
            s.gpitch = 16'($signed($urandom_range(46080)) - 23040);
            s.rroll  = ($urandom_range(3) == 0) ? 19'($signed($urandom_range(60)) - 30)
                                               : 19'($signed($urandom_range(512000)) - 256000);
            s.rpitch = ($urandom_range(3) == 0) ? 19'($signed($urandom_range(60)) - 30)
                                               : 19'($signed($urandom_range(512000)) - 256000);
        end
        return s;
    endfunction

    task automatic add_sample(logic signed [15:0] x, logic signed [15:0] y,
                              logic signed [15:0] z, logic signed [15:0] g,
                              logic signed [18:0] r);
        pending_samples.push_back({x, y, z, g, -g, r, -r});
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: zero sample, zero denominators, axis extremes, still axes.
        add_sample(0, 0, 0, 0, 0);
        add_sample(100, 0, 0, 1000, 100);
        add_sample(0, -100, 0, -1000, -100);
        add_sample(16'sh7fff, 0, 0, 16'sh7fff, 19'sh3ffff);
        add_sample(16'sh8000, 0, 0, 16'sh8000, 19'sh40000);
        add_sample(0, 16'sh7fff, 16'sh8000, 23040, 12);
        add_sample(16'sh8000, 16'sh8000, 16'sh8000, -23040, 13);
        add_sample(16'sh7fff, 16'sh7fff, 16'sh7fff, 23040, -12);
        add_sample(0, 0, 16384, 500, 0);
        add_sample(-1, 1, -1, -1, -1);
        add_sample(5000, -5000, 0, 11520, 256000);
        add_sample(-16'sd1, 16'sh7fff, 16'sh7fff, -23040, -256000);
        drain();
        write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'd0);
        write_reg(tacf_pkg::REG_STILL_THRESHOLD, 18'd0);
        add_sample(3000, -2000, 16000, 9000, 0);
        add_sample(16'sh8000, 16'sh7fff, 0, 16'sh7fff, 0);
        drain();
        write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'h0ffff);
        write_reg(tacf_pkg::REG_STILL_THRESHOLD, 18'd256000);
        add_sample(3000, -2000, 16000, 16'sh7fff, 19'sh3ffff);
        add_sample(3000, -2000, 16000, 9000, 19'sh40000);
        add_sample(-3000, 2000, 100, -9000, 255999);
        drain();
        write_reg(8'd7, 18'h3ffff);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'(tacf_pkg::GYRO_WEIGHT_RST));
                    write_reg(tacf_pkg::REG_STILL_THRESHOLD, tacf_pkg::STILL_THRESHOLD_RST);
                end
                1: begin
                    write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'($urandom));
                    write_reg(tacf_pkg::REG_STILL_THRESHOLD, 18'($urandom_range(20)));
                end
                2: begin
                    write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'd32768);
                    write_reg(tacf_pkg::REG_STILL_THRESHOLD, 18'h3ffff);
                end
                default: begin
                    write_reg(tacf_pkg::REG_GYRO_WEIGHT, 18'h0ffff);
                    write_reg(tacf_pkg::REG_STILL_THRESHOLD, 18'($urandom_range(256000)));
                end
            endcase
            for (int k = 0; k < 220; k++)
                pending_samples.push_back(random_sample($urandom_range(9) == 0));
            if (ph == 1) begin
                // Long receiver hold-off while the sender keeps offering.
                while (samples_sent < 300) @(posedge i_clk);
                @(negedge i_clk);
                hold_off = 120;
            end
            if (ph == 2) calm = 1'b1;
            drain();
            calm = 1'b0;
        end

        $display("Covered %0d results across zero, saturating and still-axis cases,",
                 angles_seen);
        $display("weights from 0 to full scale and thresholds from 0 to the maximum.");
        if (mismatches == 0 && expected_angles.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: files.f
hdl/tacf_pkg.sv
hdl/tacf_tilt.sv
hdl/tilt_angle_complementary_filter_unit.sv
dv/tilt_angle_complementary_filter_unit_tb.sv
